>>> rtl/rcpd_pkg.sv
// Package of shared constants, register codes and control types for the RC pulse decoder.
package rcpd_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int PIN_COUNT    = 4;
    localparam int TIME_W       = 32;
    localparam int PULSE_W      = 16;
    localparam int CMD_W        = 16;
    localparam int DIV_STEPS    = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 72;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SILENCE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH   = 2'd3;

    localparam logic [PULSE_W-1:0] MIN_PULSE_RST   = 16'd1000;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST   = 16'd2000;
    localparam logic [TIME_W-1:0]  MAX_SILENCE_RST = 32'd100000;
    localparam logic [TIME_W-1:0]  MAX_WIDTH_RST   = 32'd2500;

    // Channel numbers of the four receiver pins.
    localparam int CH_ROLL     = 0;
    localparam int CH_THROTTLE = 1;
    localparam int CH_PITCH    = 2;
    localparam int CH_YAW      = 3;

    localparam logic [CMD_W-1:0] CMD_SAT = 16'hFFFF;

    typedef struct packed {
        logic upd;
        logic load;
        logic step;
    } lane_ctrl_t;

    typedef struct packed {
        logic prep;
        logic load;
    } merge_ctrl_t;

endpackage

>>> rtl/rc_four_channel_pulse_decoder_core.sv
// Top level of the four-channel RC pulse-width decoder: registers, sequencer, lanes and merge.
//
//  Channel | Role   | Signals                   | Contents
//  --------+--------+---------------------------+------------------------------------------
//  s_      | input  | s_tvalid s_tready s_tdata | one pin sample with its timestamp
//  m_      | output | m_tvalid m_tready m_tdata | four commands and the link flag
//  cfg_    | config | cfg_we cfg_index cfg_wdata| floor, ceiling, silence and width limits
//
// After its acceptance a sample passes through the preparation step of clamping and link
// testing, then the restoring divider in each lane, and is then loaded into the output
// register once it is free.
// The input is ready again in the cycle after that load, even while the result still waits,
// so a new sample is not taken before the last one has been loaded into the output register.
// A stalled output keeps the sequencer waiting, with the finished quotients held in the lanes,
// until the register is free. Edges are captured at the accepting clock edge itself.
// Reset clears all edge and width state and restores the default limits; no clearing pass.
module rc_four_channel_pulse_decoder_core #(
    parameter int CHANNELS = rcpd_pkg::CHANNELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: pin_levels[3:0], time_us[35:4], zero fill [39:36].
    input  logic [rcpd_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: pitch_cmd[15:0], roll_cmd[31:16], yaw_cmd[47:32],
    // throttle_cmd[63:48], link_ok[64], zero fill [71:65].
    output logic [rcpd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_we,
    input  logic [rcpd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rcpd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import rcpd_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DONE
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [PIN_COUNT-1:0] prev_levels_reg;
    logic [TIME_W-1:0]  last_change_reg;
    logic [TIME_W-1:0]  now_reg;

    logic [PULSE_W-1:0] min_pulse_reg;
    logic [PULSE_W-1:0] max_pulse_reg;
    logic [TIME_W-1:0]  max_silence_reg;
    logic [TIME_W-1:0]  max_width_reg;

    logic [PIN_COUNT-1:0] pin_levels;
    logic [TIME_W-1:0]    time_us;
    logic                 accept;
    logic                 out_free;
    logic                 div_last;

    lane_ctrl_t  lane_ctrl;
    merge_ctrl_t merge_ctrl;

    logic [CHANNELS-1:0][TIME_W-1:0]  lane_width;
    logic [CHANNELS-1:0][CMD_W-1:0]   lane_cmd;
    logic [PIN_COUNT-1:0][CMD_W-1:0]  named_cmd;

    assign pin_levels = s_tdata[PIN_COUNT-1:0];
    assign time_us    = s_tdata[PIN_COUNT +: TIME_W];
    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid || m_tready;
    assign div_last   = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    // The result is loaded after the last divider step has settled, once the output is free.
    always_comb
    begin
        lane_ctrl.upd   = accept;
        lane_ctrl.load  = (state_reg == S_PREP);
        lane_ctrl.step  = (state_reg == S_DIV);
        merge_ctrl.prep = (state_reg == S_PREP);
        merge_ctrl.load = (state_reg == S_DONE) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg   <= MIN_PULSE_RST;
            max_pulse_reg   <= MAX_PULSE_RST;
            max_silence_reg <= MAX_SILENCE_RST;
            max_width_reg   <= MAX_WIDTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MIN_PULSE:   min_pulse_reg   <= cfg_wdata[PULSE_W-1:0];
                REG_MAX_PULSE:   max_pulse_reg   <= cfg_wdata[PULSE_W-1:0];
                REG_MAX_SILENCE: max_silence_reg <= cfg_wdata[TIME_W-1:0];
                REG_MAX_WIDTH:   max_width_reg   <= cfg_wdata[TIME_W-1:0];
                default:         ;
            endcase
        end
    end

    // Sequencer, sample history and activity time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            prev_levels_reg <= '0;
            last_change_reg <= '0;
            now_reg         <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        prev_levels_reg <= pin_levels;
                        now_reg         <= time_us;
                        if (pin_levels != prev_levels_reg)
                            last_change_reg <= time_us;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (div_last)
                        state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // One lane per channel; channels beyond the four pins see a constant low level.
    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_lane
        logic pin_cur;
        logic pin_old;

        if (i < PIN_COUNT)
        begin : g_pin
            assign pin_cur = pin_levels[i];
            assign pin_old = prev_levels_reg[i];
        end
        else
        begin : g_nopin
            assign pin_cur = 1'b0;
            assign pin_old = 1'b0;
        end

        rcpd_lane u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (lane_ctrl),
            .pin          (pin_cur),
            .pin_prev     (pin_old),
            .time_us      (time_us),
            .min_pulse_us (min_pulse_reg),
            .max_pulse_us (max_pulse_reg),
            .pulse_width  (lane_width[i]),
            .cmd          (lane_cmd[i])
        );
    end

    // A named channel with no lane behind it commands zero.
    for (genvar k = 0; k < PIN_COUNT; k++)
    begin : g_named
        if (k < CHANNELS)
        begin : g_have
            assign named_cmd[k] = lane_cmd[k];
        end
        else
        begin : g_none
            assign named_cmd[k] = '0;
        end
    end

    rcpd_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (merge_ctrl),
        .now_us         (now_reg),
        .last_change_us (last_change_reg),
        .max_silence_us (max_silence_reg),
        .max_width_us   (max_width_reg),
        .widths         (lane_width),
        .cmds           (named_cmd),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_tdata        (m_tdata)
    );

`ifndef SYNTHESIS
    a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_PREP))
        else $error("accepted sample did not move to the preparation step");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) && div_last |=> (state_reg != S_DIV))
        else $error("divider ran past its last step");

    a_failsafe_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[64] |-> (m_tdata[63:0] == 64'd0))
        else $error("commands not zeroed while the link is down");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        merge_ctrl.load |=> m_tvalid)
        else $error("loaded result not presented");
`endif

endmodule

>>> rtl/rcpd_lane.sv
// One channel lane: edge capture of pulse width, clamp and serial Q1.15 normalisation divider.
module rcpd_lane (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rcpd_pkg::lane_ctrl_t          ctrl,
    input  logic                          pin,
    input  logic                          pin_prev,
    input  logic [rcpd_pkg::TIME_W-1:0]   time_us,
    input  logic [rcpd_pkg::PULSE_W-1:0]  min_pulse_us,
    input  logic [rcpd_pkg::PULSE_W-1:0]  max_pulse_us,
    output logic [rcpd_pkg::TIME_W-1:0]   pulse_width,
    output logic [rcpd_pkg::CMD_W-1:0]    cmd
);
    import rcpd_pkg::*;

    logic [TIME_W-1:0]  rise_time_reg;
    logic [TIME_W-1:0]  pulse_width_reg;
    logic [PULSE_W-1:0] rem_reg;
    logic [PULSE_W-1:0] bits_reg;
    logic [CMD_W-1:0]   quot_reg;
    logic               zero_reg;
    logic               sat_reg;

    logic [TIME_W-1:0]  floor_w;
    logic [PULSE_W-1:0] clamped;
    logic [PULSE_W-1:0] diff;
    logic [PULSE_W:0]   trial;
    logic               take;

    always_comb
    begin
        floor_w = (pulse_width_reg < {16'd0, min_pulse_us}) ? {16'd0, min_pulse_us}
                                                           : pulse_width_reg;
        clamped = (floor_w > {16'd0, max_pulse_us}) ? max_pulse_us : floor_w[PULSE_W-1:0];
        diff    = clamped - min_pulse_us;
        trial   = {rem_reg, bits_reg[PULSE_W-1]};
        take    = (trial >= {1'b0, min_pulse_us});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_time_reg   <= '0;
            pulse_width_reg <= '0;
        end
        else if (ctrl.upd && (pin != pin_prev))
        begin
            if (pin)
                rise_time_reg <= time_us;
            else
                pulse_width_reg <= time_us - rise_time_reg;
        end
    end

    // Restoring division of (diff << 15) by the floor; the top 16 dividend bits
    // are already below the divisor whenever the result does not saturate.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            zero_reg <= (clamped <= min_pulse_us);
            sat_reg  <= ({1'b0, diff} >= {min_pulse_us, 1'b0});
            rem_reg  <= {1'b0, diff[PULSE_W-1:1]};
            bits_reg <= {diff[0], {(PULSE_W-1){1'b0}}};
            quot_reg <= '0;
        end
        else if (ctrl.step)
        begin
            rem_reg  <= take ? PULSE_W'(trial - {1'b0, min_pulse_us}) : trial[PULSE_W-1:0];
            bits_reg <= {bits_reg[PULSE_W-2:0], 1'b0};
            quot_reg <= {quot_reg[CMD_W-2:0], take};
        end
    end

    assign pulse_width = pulse_width_reg;
    assign cmd = zero_reg ? '0 : (sat_reg ? CMD_SAT : quot_reg);

endmodule

>>> rtl/rcpd_merge.sv
// Merging stage: link test over all lanes and the registered result of one transaction.
module rcpd_merge #(
    parameter int CHANNELS = rcpd_pkg::CHANNELS_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  rcpd_pkg::merge_ctrl_t                    ctrl,
    input  logic [rcpd_pkg::TIME_W-1:0]              now_us,
    input  logic [rcpd_pkg::TIME_W-1:0]              last_change_us,
    input  logic [rcpd_pkg::TIME_W-1:0]              max_silence_us,
    input  logic [rcpd_pkg::TIME_W-1:0]              max_width_us,
    input  logic [CHANNELS-1:0][rcpd_pkg::TIME_W-1:0] widths,
    input  logic [rcpd_pkg::PIN_COUNT-1:0][rcpd_pkg::CMD_W-1:0] cmds,
    input  logic                                     m_tready,
    output logic                                     m_tvalid,
    output logic [rcpd_pkg::OUT_TDATA_W-1:0]         m_tdata
);
    import rcpd_pkg::*;

    logic                   link_reg;
    logic                   valid_reg;
    logic [OUT_TDATA_W-1:0] data_reg;
    logic                   widths_ok;
    logic [TIME_W-1:0]      silence;

    always_comb
    begin
        widths_ok = 1'b1;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (widths[i] >= max_width_us)
                widths_ok = 1'b0;
        end
        silence = now_us - last_change_us;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.prep)
            link_reg <= widths_ok && (silence < max_silence_us);
        if (ctrl.load)
        begin
            if (link_reg)
                data_reg <= {7'd0, 1'b1, cmds[CH_THROTTLE], cmds[CH_YAW],
                             cmds[CH_ROLL], cmds[CH_PITCH]};
            else
                data_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ctrl.load)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

>>> tb/rc_four_channel_pulse_decoder_core_tb.sv
// Self-checking testbench for the four-channel RC pulse-width decoder core.
`timescale 1ns / 1ps

module rc_four_channel_pulse_decoder_core_tb;

    import rcpd_pkg::*;

    // Cycles without any transaction on either stream or the register port
    // before the run is declared hung. The limit exceeds the time that the slowest
    // correct item spends in the block plus the longest sender gap and the longest
    // receiver stall, so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 4000;

    // One pin sample as it travels on the input stream.
    typedef struct packed {
        logic [3:0]  levels;
        logic [31:0] stamp;
    } pin_sample_t;

    // The decoded commands of one sample, in the order they sit on the output.
    typedef struct packed {
        logic [15:0] pitch;
        logic [15:0] roll;
        logic [15:0] yaw;
        logic [15:0] throttle;
        logic        link_ok;
    } cmd_set_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    // Fields from bit 0: pin_levels[3:0], time_us[35:4], zero fill [39:36].
    logic [IN_TDATA_W-1:0]      s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    // Fields from bit 0: pitch_cmd[15:0], roll_cmd[31:16], yaw_cmd[47:32],
    // throttle_cmd[63:48], link_ok[64], zero fill [71:65].
    logic [OUT_TDATA_W-1:0]     m_tdata;
    logic                       cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = REG_MIN_PULSE;
    logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

    // Samples waiting to be offered, and the command sets still owed by the block.
    pin_sample_t                pending_samples_q[$];
    cmd_set_t                   expected_cmds_q[$];

    // Shadow copy of the limit registers, starting from their reset values.
    logic [15:0]                lim_min = MIN_PULSE_RST;
    logic [15:0]                lim_max = MAX_PULSE_RST;
    logic [31:0]                lim_silence = MAX_SILENCE_RST;
    logic [31:0]                lim_width = MAX_WIDTH_RST;

    // Decoder state as the block should hold it after each accepted sample.
    logic [3:0]                 pred_levels = '0;
    logic [31:0]                pred_rise [4] = '{default: '0};
    logic [31:0]                pred_width [4] = '{default: '0};
    logic [31:0]                pred_last_change = '0;

    // Generator view of the pins, so that frames can be built on top of it.
    logic [3:0]                 gen_levels = '0;
    logic [31:0]                gen_stamp = '0;
    logic [31:0]                gen_last_change = '0;
    int                         gen_count = 0;

    int                         mismatch_count = 0;
    int                         burst_left = 0;
    int                         gap_left = 0;
    int                         stall_mode = 0;
    int                         mode_left = 0;
    int                         idle_cycles = 0;

    rc_four_channel_pulse_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Clamp a raw width into the floor and ceiling and scale it to unsigned
    // Q1.15 relative to the floor. A floor above the ceiling leaves the ceiling,
    // which then lies at or below the floor and gives zero. A zero floor makes
    // any nonzero clamped width saturate.
    function automatic logic [15:0] scale_width(input logic [31:0] w);
        logic [31:0] c;
        logic [63:0] diff;
        logic [63:0] q;
        c = w;
        if (c < {16'd0, lim_min})
            c = {16'd0, lim_min};
        if (c > {16'd0, lim_max})
            c = {16'd0, lim_max};
        if (c <= {16'd0, lim_min})
            return 16'd0;
        if (lim_min == 16'd0)
            return CMD_SAT;
        diff = {32'd0, c - {16'd0, lim_min}};
        q = (diff << 15) / {48'd0, lim_min};
        return (q > 64'd65535) ? CMD_SAT : q[15:0];
    endfunction

    // Advance the decoder state by one sample and return the commands it yields.
    function automatic cmd_set_t decode_sample(input logic [3:0] lv, input logic [31:0] now);
        logic [3:0]  changed;
        logic [31:0] widest;
        logic [31:0] quiet;
        cmd_set_t    r;
        int          ch;
        changed = lv ^ pred_levels;
        widest = '0;
        for (ch = 0; ch < 4; ch++)
        begin
            if (changed[ch])
            begin
                if (lv[ch])
                    pred_rise[ch] = now;
                else
                    pred_width[ch] = now - pred_rise[ch];
            end
            if (pred_width[ch] > widest)
                widest = pred_width[ch];
        end
        if (changed != 4'd0)
            pred_last_change = now;
        pred_levels = lv;
        quiet = now - pred_last_change;
        r = '0;
        // The link holds only while the pins have moved recently enough and no
        // channel has reported a width at or beyond the allowed limit.
        if (quiet < lim_silence && widest < lim_width)
        begin
            r.pitch    = scale_width(pred_width[CH_PITCH]);
            r.roll     = scale_width(pred_width[CH_ROLL]);
            r.yaw      = scale_width(pred_width[CH_YAW]);
            r.throttle = scale_width(pred_width[CH_THROTTLE]);
            r.link_ok  = 1'b1;
        end
        return r;
    endfunction

    // Sender. Samples go out in bursts of random length; between bursts the
    // valid line drops for a random number of cycles, sometimes none at all, so
    // that the gaps land on every cycle of the divider's work. The expected
    // commands are worked out at the moment a transaction is accepted.
    always @(posedge clk)
    begin
        pin_sample_t smp;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_cmds_q.push_back(decode_sample(s_tdata[3:0], s_tdata[35:4]));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_samples_q.size() > 0)
                begin
                    smp = pending_samples_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'd0, smp.stamp, smp.levels};
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                                 : $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver. The ready line follows a pattern that switches between always
    // ready, mostly ready, mostly stalled and long regular stalls. Every
    // accepted transaction is checked against the oldest expected command set.
    always @(posedge clk)
    begin
        cmd_set_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_cmds_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %h", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = expected_cmds_q.pop_front();
                check_field("pitch_cmd", want.pitch, m_tdata[15:0]);
                check_field("roll_cmd", want.roll, m_tdata[31:16]);
                check_field("yaw_cmd", want.yaw, m_tdata[47:32]);
                check_field("throttle_cmd", want.throttle, m_tdata[63:48]);
                check_field("link_ok", want.link_ok, m_tdata[64]);
            end
        end
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(10, 200);
        end
        else
        begin
            mode_left--;
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) < 7);
            2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (mode_left % 37 == 0);
        endcase
    end

    // Watchdog: ends the run if no transaction of any kind happens for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[rc_four_channel_pulse_decoder_core] ERROR");
            $finish;
        end
    end

    task automatic push_sample(input logic [3:0] lv, input logic [31:0] stamp);
        pin_sample_t smp;
        if (lv != gen_levels)
            gen_last_change = stamp;
        gen_levels = lv;
        gen_stamp = stamp;
        smp.levels = lv;
        smp.stamp = stamp;
        pending_samples_q.push_back(smp);
        gen_count++;
    endtask

    // Pulse width for one channel of a frame, mostly around the clamp window
    // but with the boundaries and the failsafe limit hit on purpose.
    function automatic logic [31:0] pick_width();
        logic [31:0] lo;
        logic [31:0] hi;
        int          sel;
        lo = (lim_min < lim_max) ? {16'd0, lim_min} : {16'd0, lim_max};
        hi = (lim_min < lim_max) ? {16'd0, lim_max} : {16'd0, lim_min};
        lo = lo - lo / 4;
        hi = hi + hi / 4;
        sel = $urandom_range(0, 19);
        case (sel)
            0: return 32'd0;
            1: return lim_width - 32'd1;
            2: return lim_width;
            3: return $urandom;
            4: return {16'd0, lim_min};
            5: return {16'd0, lim_max};
            6: return {16'd0, lim_max} + 32'd1;
            7: return {16'd0, lim_min} + 32'd1;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // A receiver frame: a set of pins rises together, then each falls after
    // its own width, the falls issued in time order.
    task automatic add_frame();
        logic [31:0] t0;
        logic [3:0]  mask;
        logic [3:0]  lv;
        logic [31:0] w [4];
        int          order [4];
        int          i;
        int          j;
        int          tmp;
        t0 = gen_stamp + $urandom_range(50, 3000);
        mask = ($urandom_range(0, 3) != 0) ? 4'hF : 4'($urandom_range(1, 15));
        push_sample(mask, t0);
        for (i = 0; i < 4; i++)
        begin
            w[i] = pick_width();
            order[i] = i;
        end
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3 - i; j++)
                if (w[order[j]] > w[order[j + 1]])
                begin
                    tmp = order[j];
                    order[j] = order[j + 1];
                    order[j + 1] = tmp;
                end
        lv = mask;
        for (i = 0; i < 4; i++)
            if (mask[order[i]])
            begin
                lv[order[i]] = 1'b0;
                push_sample(lv, t0 + w[order[i]]);
            end
    endtask

    // A sample without any pin change, often placed right at the edge of the
    // silence limit so that both sides of it are seen.
    task automatic add_quiet();
        if ($urandom_range(0, 1) == 0)
            push_sample(gen_levels, gen_last_change + lim_silence - 32'd2 + $urandom_range(0, 3));
        else
            push_sample(gen_levels, gen_stamp + $urandom_range(0, 2000));
    endtask

    task automatic add_noise();
        logic [3:0]  lv;
        logic [31:0] stamp;
        lv = 4'($urandom_range(0, 15));
        stamp = ($urandom_range(0, 3) == 0) ? $urandom : gen_stamp + $urandom_range(0, 5000);
        push_sample(lv, stamp);
    endtask

    task automatic run_random(input int n);
        int start;
        int r;
        start = gen_count;
        while (gen_count - start < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                add_frame();
            else if (r < 85)
                add_quiet();
            else
                add_noise();
        end
    endtask

    // Wait until every sample has been offered and accepted and every command
    // set has come back, then let the pipeline settle for its full latency.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_samples_q.size() != 0 || s_tvalid || expected_cmds_q.size() != 0);
        repeat (24) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_MIN_PULSE:   lim_min = data[15:0];
            REG_MAX_PULSE:   lim_max = data[15:0];
            REG_MAX_SILENCE: lim_silence = data;
            default:         lim_width = data;
        endcase
    endtask

    task automatic set_limits(input logic [15:0] mn, input logic [15:0] mx,
                              input logic [31:0] sil, input logic [31:0] wid);
        wait_idle();
        write_reg(REG_MIN_PULSE, {16'd0, mn});
        write_reg(REG_MAX_PULSE, {16'd0, mx});
        write_reg(REG_MAX_SILENCE, sil);
        write_reg(REG_MAX_WIDTH, wid);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] mn;
        logic [31:0] mx;
        int          k;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with the reset limits: a pulse in the middle of the
        // window, one on the ceiling, one clamped to the ceiling, one at the
        // failsafe width, silence one below and at the limit, timestamps
        // wrapping through zero, widths of zero, below the floor and above the
        // ceiling, and a huge width that is later cleared by a fresh frame.
        push_sample(4'h0, 32'd0);
        push_sample(4'hF, 32'd10);
        push_sample(4'hE, 32'd1510);
        push_sample(4'hC, 32'd2010);
        push_sample(4'h8, 32'd2410);
        push_sample(4'h0, 32'd2510);
        push_sample(4'h1, 32'd3000);
        push_sample(4'hF, 32'd3000);
        push_sample(4'h0, 32'd4000);
        push_sample(4'h0, 32'd103999);
        push_sample(4'h0, 32'd104000);
        push_sample(4'hF, 32'hFFFF_FF00);
        push_sample(4'h0, 32'h0000_0400);
        push_sample(4'h5, 32'hFFFF_FFFF);
        push_sample(4'hA, 32'hFFFF_FFFF);
        push_sample(4'h0, 32'h0000_07CF);
        push_sample(4'hF, 32'h1000_0000);
        push_sample(4'h3, 32'h1000_0000 + 32'd999);
        push_sample(4'h0, 32'h1000_0000 + 32'd2001);
        push_sample(4'hF, 32'h5555_5555);
        push_sample(4'h0, 32'hAAAA_AAAA);
        push_sample(4'hF, 32'hAAAB_0000);
        push_sample(4'h0, 32'hAAAB_0000 + 32'd1750);

        // Reset values written explicitly, then the extreme settings: the
        // narrowest limits, a floor of one with everything else wide open so
        // that commands saturate, the floor above the ceiling, floor equal to
        // ceiling, and a zero floor.
        set_limits(16'd1000, 16'd2000, 32'd100000, 32'd2500);
        run_random(120);
        set_limits(16'd1, 16'd65535, 32'd1, 32'd1);
        run_random(60);
        set_limits(16'd1, 16'd65535, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(100);
        set_limits(16'd65535, 16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(80);
        set_limits(16'd65535, 16'd65535, 32'd200000, 32'd100000);
        run_random(60);
        set_limits(16'd0, 16'd3000, 32'd100000, 32'd5000);
        run_random(80);

        // Random settings around typical receiver timing, now and then with a
        // floor anywhere in its range.
        for (k = 0; k < 7; k++)
        begin
            mn = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                             : 16'($urandom_range(200, 5000));
            mx = {16'd0, mn} + $urandom_range(0, 2 * mn);
            if (mx > 32'd65535)
                mx = 32'd65535;
            set_limits(mn, mx[15:0], $urandom_range(2000, 200000),
                       mx + $urandom_range(0, mx) + 32'd1);
            run_random(150);
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("[rc_four_channel_pulse_decoder_core] OK");
        else
            $display("[rc_four_channel_pulse_decoder_core] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/rcpd_pkg.sv
rtl/rcpd_lane.sv
rtl/rcpd_merge.sv
rtl/rc_four_channel_pulse_decoder_core.sv
tb/rc_four_channel_pulse_decoder_core_tb.sv
